@@ rtl/sfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sfs_pkg - shared types and constants for the sprite frame sequencer
// Request payload structs, action and register codes, default parameters.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int FRAME_W        = 6;   // width of a frame number on the ports
  localparam int STATE_W        = 2;   // width of a state index
  localparam int TICK_W         = 9;   // prescaler width
  localparam int PERIOD_W       = 8;   // per-state tick period width
  localparam int MASK_W         = 64;  // stop mask width
  localparam int STATE_SLOTS    = 4;   // state slots in the register file
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int FRAMES_REG_W   = STATE_SLOTS * FRAME_W;
  localparam int PERIODS_REG_W  = STATE_SLOTS * PERIOD_W;

  localparam int DEF_STATE_COUNT = 4;
  localparam int DEF_FRAME_BITS  = 6;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_SET_STATE = 3'd1,
    ACT_START     = 3'd2,
    ACT_CARRY_ON  = 3'd3,
    ACT_END       = 3'd4,
    ACT_FINISH    = 3'd5,
    ACT_SET_DIR   = 3'd6
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_FRAMES = 3'd0,
    REG_LAST_FRAMES  = 3'd1,
    REG_TICK_PERIODS = 3'd2,
    REG_STOP_MASK_0  = 3'd3,
    REG_STOP_MASK_1  = 3'd4,
    REG_STOP_MASK_2  = 3'd5,
    REG_STOP_MASK_3  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [STATE_W-1:0] target_state;
    logic               play_backward;
  } sfs_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_now;
    logic               is_running;
    logic [STATE_W-1:0] state_now;
  } sfs_out_t;

endpackage

@@ rtl/sprite_frame_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_core - sprite animation frame sequencer
// Steps through the frames of one of up to four animation states under
// tick and command requests; one status result per request.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload     | Direction
//  --------+-----------------------+-------------+----------
//  in_     | in_valid / in_ready   | sfs_in_t    | request in
//  out_    | out_valid / out_ready | sfs_out_t   | status out
//  cfg_    | cfg_wr_en (no wait)   | cfg_wdata   | register write
//
//  One request per cycle unless out_ stalls; its status appears in the cycle
//  after it is taken, from the single output register fed by the update logic.
//  in_ready stays high while that register is empty or being drained, so a
//  stall on out_ stops input only once a status is actually waiting.
//  Reset (rst_n low, synchronous) clears the sequencer state, the register
//  file and the output valid flag.
//
module sprite_frame_sequencer_core #(
  parameter int STATE_COUNT = sfs_pkg::DEF_STATE_COUNT,  // 1..4
  parameter int FRAME_BITS  = sfs_pkg::DEF_FRAME_BITS    // 1..6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sfs_pkg::sfs_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sfs_pkg::sfs_out_t                  out_data,
  input  logic                               cfg_wr_en,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sfs_pkg::*;

  // state limit at one bit more than a state index so that four fits
  localparam logic [STATE_W:0] STATE_LIMIT = (STATE_W + 1)'(STATE_COUNT);

  // register file
  logic [FRAMES_REG_W-1:0]  first_frames_r;
  logic [FRAMES_REG_W-1:0]  last_frames_r;
  logic [PERIODS_REG_W-1:0] tick_periods_r;
  logic [MASK_W-1:0]        stop_mask_r [STATE_SLOTS];

  // sequencer state
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;
  logic [STATE_W-1:0]    state_r, state_nxt;
  logic                  running_r, running_nxt;
  logic                  finish_req_r, finish_req_nxt;
  logic                  backward_r, backward_nxt;

  logic     out_valid_r;
  sfs_out_t out_data_r;

  logic in_take;
  assign in_ready = !out_valid_r || out_ready;
  assign in_take  = in_valid && in_ready;

  // ---- configuration writes ------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_frames_r <= '0;
      last_frames_r  <= '0;
      tick_periods_r <= '0;
      for (int i = 0; i < STATE_SLOTS; i++) stop_mask_r[i] <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FIRST_FRAMES: first_frames_r <= cfg_wdata[FRAMES_REG_W-1:0];
        REG_LAST_FRAMES:  last_frames_r  <= cfg_wdata[FRAMES_REG_W-1:0];
        REG_TICK_PERIODS: tick_periods_r <= cfg_wdata[PERIODS_REG_W-1:0];
        REG_STOP_MASK_0:  stop_mask_r[0] <= cfg_wdata[MASK_W-1:0];
        REG_STOP_MASK_1:  stop_mask_r[1] <= cfg_wdata[MASK_W-1:0];
        REG_STOP_MASK_2:  stop_mask_r[2] <= cfg_wdata[MASK_W-1:0];
        REG_STOP_MASK_3:  stop_mask_r[3] <= cfg_wdata[MASK_W-1:0];
        default: ;  // index beyond the register list: dropped
      endcase
    end
  end

  // ---- per-state fields of the active state --------------------------------
  logic [FRAME_W-1:0]    first_raw, last_raw, target_first_raw;
  logic [FRAME_BITS-1:0] first_cur, last_cur, target_first;
  logic [PERIOD_W-1:0]   period_cur;
  logic [MASK_W-1:0]     mask_cur;

  assign first_raw        = first_frames_r[state_r*FRAME_W +: FRAME_W];
  assign last_raw         = last_frames_r[state_r*FRAME_W +: FRAME_W];
  assign target_first_raw = first_frames_r[in_data.target_state*FRAME_W +: FRAME_W];
  // frame numbers are taken modulo the frame range
  assign first_cur    = first_raw[FRAME_BITS-1:0];
  assign last_cur     = last_raw[FRAME_BITS-1:0];
  assign target_first = target_first_raw[FRAME_BITS-1:0];
  assign period_cur   = tick_periods_r[state_r*PERIOD_W +: PERIOD_W];
  assign mask_cur     = stop_mask_r[state_r];

  // ---- tick datapath -------------------------------------------------------
  logic [TICK_W-1:0]     tick_inc;
  logic                  tick_wrap;
  logic [FRAME_BITS:0]   fwd_sum;     // one extra bit so the top frame wraps
  logic [FRAME_BITS-1:0] bwd_dec;
  logic [FRAME_BITS-1:0] step_frame;
  logic [FRAME_W-1:0]    step_frame_ext;
  logic                  stop_hit;

  assign tick_inc  = tick_r + TICK_W'(1);
  assign tick_wrap = tick_inc > TICK_W'(period_cur);
  assign fwd_sum   = {1'b0, frame_r} + (FRAME_BITS + 1)'(1);
  assign bwd_dec   = frame_r - FRAME_BITS'(1);

  always_comb begin
    if (!backward_r) begin
      step_frame = (fwd_sum > {1'b0, last_cur}) ? first_cur : fwd_sum[FRAME_BITS-1:0];
    end else begin
      // below zero or below first goes to last
      step_frame = (frame_r == '0 || bwd_dec < first_cur) ? last_cur : bwd_dec;
    end
  end

  assign step_frame_ext = FRAME_W'(step_frame);
  assign stop_hit       = finish_req_r && mask_cur[step_frame_ext];

  // ---- next state ----------------------------------------------------------
  always_comb begin
    frame_nxt      = frame_r;
    tick_nxt       = tick_r;
    state_nxt      = state_r;
    running_nxt    = running_r;
    finish_req_nxt = finish_req_r;
    backward_nxt   = backward_r;
    case (in_data.action)
      ACT_TICK: begin
        if (running_r) begin
          if (tick_wrap) begin
            tick_nxt  = '0;
            frame_nxt = step_frame;
            if (stop_hit) running_nxt = 1'b0;
          end else begin
            tick_nxt = tick_inc;
          end
        end
      end
      ACT_SET_STATE: begin
        // out-of-range or unchanged state: ignored
        if ({1'b0, in_data.target_state} < STATE_LIMIT &&
            in_data.target_state != state_r) begin
          state_nxt = in_data.target_state;
          tick_nxt  = '0;
          frame_nxt = target_first;
        end
      end
      ACT_START: begin
        running_nxt    = 1'b1;
        finish_req_nxt = 1'b0;
        tick_nxt       = '0;
        frame_nxt      = first_cur;
      end
      ACT_CARRY_ON: begin
        running_nxt    = 1'b1;
        finish_req_nxt = 1'b0;
      end
      ACT_END:     running_nxt    = 1'b0;
      ACT_FINISH:  finish_req_nxt = 1'b1;  // stays set until start or carry on
      ACT_SET_DIR: backward_nxt   = in_data.play_backward;
      default: ;   // unused action code
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r      <= '0;
      tick_r       <= '0;
      state_r      <= '0;
      running_r    <= 1'b0;
      finish_req_r <= 1'b0;
      backward_r   <= 1'b0;
    end else if (in_take) begin
      frame_r      <= frame_nxt;
      tick_r       <= tick_nxt;
      state_r      <= state_nxt;
      running_r    <= running_nxt;
      finish_req_r <= finish_req_nxt;
      backward_r   <= backward_nxt;
    end
  end

  // ---- status register -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r.frame_now  <= FRAME_W'(frame_nxt);
      out_data_r.is_running <= running_nxt;
      out_data_r.state_now  <= state_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/sfs_checker.sv @@
// ----------------------------------------------------------------------------
// sfs_port_checks - port-level checks for the sprite frame sequencer
// Watches the top-level ports; attached by the bind at the end of the file.
// ----------------------------------------------------------------------------
module sfs_port_checks (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input sfs_pkg::sfs_in_t               in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input sfs_pkg::sfs_out_t              out_data
);
  import sfs_pkg::*;

  logic in_take;
  assign in_take = in_valid && in_ready;

  // an empty status register never blocks a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with no status pending");

  // every taken request yields a status in the next cycle
  a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid)
    else $error("no status after a taken request");

  // a waiting status holds
  a_status_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled status changed or dropped");

  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_data.action == ACT_END |=> !out_data.is_running)
    else $error("still running after end");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && (in_data.action == ACT_START || in_data.action == ACT_CARRY_ON)
    |=> out_data.is_running)
    else $error("not running after start or carry on");

endmodule

bind sprite_frame_sequencer_core sfs_port_checks u_sfs_checker (.*);
